>>> rtl/core/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_RESTART = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    localparam int STEP_W  = 5;
    localparam int PHASE_W = 2;

    localparam logic [STEP_W-1:0] WR_ACK_STEP  = 5'd24;
    localparam logic [STEP_W-1:0] WR_LAST_STEP = 5'd26;
    localparam logic [STEP_W-1:0] RD_BIT_FIRST = 5'd2;
    localparam logic [STEP_W-1:0] RD_BIT_LAST  = 5'd17;
    localparam logic [STEP_W-1:0] RD_ACK_SCL   = 5'd18;
    localparam logic [STEP_W-1:0] RD_ACK_SDA   = 5'd19;
    localparam logic [STEP_W-1:0] RD_LAST_STEP = 5'd20;

    localparam logic [PHASE_W-1:0] PH_SCL_LO = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SDA    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SCL_HI = 2'd2;

    // one pin step: which line is set, the level, and end of primitive
    typedef struct packed {
        logic sel_sda;
        logic level;
        logic last;
    } t_action;

endpackage

>>> rtl/core/i2cbs_step.sv
// ----------------------------------------------------------------------------
// i2cbs_step
// Decodes the pin action for a given primitive, step index and bit phase.
// ----------------------------------------------------------------------------
module i2cbs_step import i2cbs_pkg::*; (
    input  logic [2:0]         i_op,
    input  logic [STEP_W-1:0]  i_step,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic               i_tx_bit,
    output t_action            o_act
);

    always_comb begin
        o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
        case (t_op'(i_op))
            OP_START: begin
                case (i_step)
                    5'd0:    o_act = '{sel_sda: 1'b1, level: 1'b1, last: 1'b0};
                    5'd1:    o_act = '{sel_sda: 1'b0, level: 1'b1, last: 1'b0};
                    default: o_act = '{sel_sda: 1'b1, level: 1'b0, last: 1'b1};
                endcase
            end
            OP_RESTART: begin
                case (i_step)
                    5'd0:    o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                    5'd1:    o_act = '{sel_sda: 1'b1, level: 1'b1, last: 1'b0};
                    5'd2:    o_act = '{sel_sda: 1'b0, level: 1'b1, last: 1'b0};
                    default: o_act = '{sel_sda: 1'b1, level: 1'b0, last: 1'b1};
                endcase
            end
            OP_STOP: begin
                case (i_step)
                    5'd0:    o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                    5'd1:    o_act = '{sel_sda: 1'b1, level: 1'b0, last: 1'b0};
                    5'd2:    o_act = '{sel_sda: 1'b0, level: 1'b1, last: 1'b0};
                    default: o_act = '{sel_sda: 1'b1, level: 1'b1, last: 1'b1};
                endcase
            end
            OP_WRITE: begin
                case (i_phase)
                    PH_SCL_LO: o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                    PH_SDA: begin
                        // ack slot releases SDA
                        o_act = '{sel_sda: 1'b1,
                                  level:   (i_step < WR_ACK_STEP) ? i_tx_bit : 1'b1,
                                  last:    1'b0};
                    end
                    PH_SCL_HI: begin
                        o_act = '{sel_sda: 1'b0, level: 1'b1,
                                  last: (i_step == WR_LAST_STEP)};
                    end
                    default: o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                endcase
            end
            OP_READ: begin
                if (i_step >= RD_BIT_FIRST && i_step <= RD_BIT_LAST) begin
                    o_act = '{sel_sda: 1'b0, level: i_step[0], last: 1'b0};
                end else begin
                    case (i_step)
                        5'd0:         o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                        5'd1:         o_act = '{sel_sda: 1'b1, level: 1'b1, last: 1'b0};
                        RD_ACK_SCL:   o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b0};
                        RD_ACK_SDA:   o_act = '{sel_sda: 1'b1, level: 1'b0, last: 1'b0};
                        default:      o_act = '{sel_sda: 1'b0, level: 1'b1, last: 1'b1};
                    endcase
                end
            end
            default: o_act = '{sel_sda: 1'b0, level: 1'b0, last: 1'b1};
        endcase
    end

endmodule

>>> rtl/core/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// I2C master line sequencer: one bus primitive in, one word per pin step out.
// ----------------------------------------------------------------------------
// Each accepted primitive yields one output word per cycle while the output is
// ready, one word for each of its pin steps: start 3, repeated start 4, stop 4,
// write byte 27, read byte 21. The single output register takes one pin step
// per cycle while the output is ready. Undefined opcodes are consumed with no
// output. A holding register on the input takes the next primitive while the
// current one runs, and it starts with no gap after the last step of the one
// before.
module i2c_master_bit_sequencer_top import i2cbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op, [10:3] tx_byte, [11] line_ack, [19:12] line_byte, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [9:2] rx_byte, [10] nack, [15:11] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic        r_in_valid;
    logic [23:0] r_in_data;

    logic               r_busy;
    logic [2:0]         r_op;
    logic [7:0]         r_tx;
    logic               r_ack;
    logic [7:0]         r_rxin;
    logic [STEP_W-1:0]  r_step;
    logic [PHASE_W-1:0] r_phase;
    logic               r_scl;
    logic               r_sda;

    logic       r_out_valid;
    logic       r_out_scl;
    logic       r_out_sda;
    logic [7:0] r_out_rx;
    logic       r_out_nack;
    logic       r_out_last;

    t_action w_act;
    logic    w_adv;
    logic    w_load;
    logic    w_op_ok;
    logic    n_scl;
    logic    n_sda;

    i2cbs_step u_step (
        .i_op     (r_op),
        .i_step   (r_step),
        .i_phase  (r_phase),
        .i_tx_bit (r_tx[7]),
        .o_act    (w_act)
    );

    assign w_adv   = r_busy && (!r_out_valid || m_axis_tready);
    assign w_load  = r_in_valid && (!r_busy || (w_adv && w_act.last));
    assign w_op_ok = (r_in_data[2:0] <= 3'(OP_READ));
    assign n_scl   = w_act.sel_sda ? r_scl : w_act.level;
    assign n_sda   = w_act.sel_sda ? w_act.level : r_sda;

    assign s_axis_tready = !r_in_valid || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_phase     <= PH_SCL_LO;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_data  <= s_axis_tdata;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
                r_out_scl   <= n_scl;
                r_out_sda   <= n_sda;
                r_out_last  <= w_act.last;
                r_out_rx    <= (w_act.last && r_op == 3'(OP_READ)) ? r_rxin : 8'd0;
                r_out_nack  <= w_act.last && r_op == 3'(OP_WRITE) && r_ack;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_load) begin
                r_busy  <= w_op_ok;
                r_op    <= r_in_data[2:0];
                r_tx    <= r_in_data[10:3];
                r_ack   <= r_in_data[11];
                r_rxin  <= r_in_data[19:12];
                r_step  <= '0;
                r_phase <= PH_SCL_LO;
            end else if (w_adv) begin
                r_step  <= r_step + 1'b1;
                r_phase <= (r_phase == PH_SCL_HI) ? PH_SCL_LO : r_phase + 1'b1;
                if (w_act.sel_sda && r_op == 3'(OP_WRITE)) begin
                    r_tx <= {r_tx[6:0], 1'b0};
                end
                if (w_act.last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'd0, r_out_nack, r_out_rx, r_out_sda, r_out_scl};

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("bit phase out of range");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= WR_LAST_STEP)
        else $error("step index beyond longest primitive");

    a_last_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_act.last) |=> (r_out_scl && r_out_last))
        else $error("primitive ended with SCL low");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (!r_out_nack && r_out_rx == 8'd0))
        else $error("status fields set before last word");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_busy || w_act.last))
        else $error("new primitive loaded mid-run");
`endif

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit sequencer.
// Bus primitives go in on the slave stream. Every pin-step word that comes
// out is checked against a line-level predictor that tracks the SCL and SDA
// drives. A directed list covers each primitive, the byte extremes, ack and
// nack, and the undefined opcodes. Random transactions follow, with random
// idle bursts on both streams and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import i2cbs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_TAIL   = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [3:0] zero;
        logic [7:0] line_byte;
        logic       line_ack;
        logic [7:0] tx_byte;
        logic [2:0] op;
    } t_prim;

    typedef struct packed {
        logic [4:0] zero;
        logic       nack;
        logic [7:0] rx_byte;
        logic       sda;
        logic       scl;
    } t_pin_word;

    typedef struct {
        t_pin_word w;
        logic      eop;
    } t_pin_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    i2c_master_bit_sequencer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [2:0] op, [10:3] tx_byte, [11] line_ack,
                                         // [19:12] line_byte, [23:20] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] scl_level, [1] sda_level, [9:2] rx_byte,
                                         // [10] nack, [15:11] zero
        .m_axis_tlast  (m_axis_tlast)
    );

    t_prim     prim_q[$];
    t_pin_step pin_steps_q[$];
    logic      scl_drv = 1'b1;
    logic      sda_drv = 1'b1;
    int        errors = 0;
    int        n_prims_in;
    int        cycles = 0;
    int        gap;
    int        stall;
    int        hold;
    logic      held_once;
    logic      quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- line predictor ----------------
    function automatic void drive_scl(input logic v);
        t_pin_step s;
        scl_drv = v;
        s.w = '0;
        s.w.scl = scl_drv;
        s.w.sda = sda_drv;
        s.eop = 1'b0;
        pin_steps_q.push_back(s);
    endfunction

    function automatic void drive_sda(input logic v);
        t_pin_step s;
        sda_drv = v;
        s.w = '0;
        s.w.scl = scl_drv;
        s.w.sda = sda_drv;
        s.eop = 1'b0;
        pin_steps_q.push_back(s);
    endfunction

    function automatic void sequence_primitive(input t_prim p);
        t_pin_step s;
        case (p.op)
            OP_START: begin
                drive_sda(1'b1);
                drive_scl(1'b1);
                drive_sda(1'b0);
            end
            OP_RESTART: begin
                drive_scl(1'b0);
                drive_sda(1'b1);
                drive_scl(1'b1);
                drive_sda(1'b0);
            end
            OP_STOP: begin
                drive_scl(1'b0);
                drive_sda(1'b0);
                drive_scl(1'b1);
                drive_sda(1'b1);
            end
            OP_WRITE: begin
                for (int b = 7; b >= 0; b--) begin
                    drive_scl(1'b0);
                    drive_sda(p.tx_byte[b]);
                    drive_scl(1'b1);
                end
                drive_scl(1'b0);
                drive_sda(1'b1);
                drive_scl(1'b1);
            end
            OP_READ: begin
                drive_scl(1'b0);
                drive_sda(1'b1);
                for (int b = 7; b >= 0; b--) begin
                    drive_scl(1'b0);
                    drive_scl(1'b1);
                end
                drive_scl(1'b0);
                drive_sda(1'b0);
                drive_scl(1'b1);
            end
            default: return;
        endcase
        s = pin_steps_q.pop_back();
        s.eop = 1'b1;
        if (p.op == OP_WRITE) s.w.nack = p.line_ack;
        if (p.op == OP_READ) s.w.rx_byte = p.line_byte;
        pin_steps_q.push_back(s);
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void queue_prim(input logic [2:0] op, input logic [7:0] tx,
                                       input logic ack, input logic [7:0] rxb);
        t_prim p;
        p.zero = '0;
        p.op = op;
        p.tx_byte = tx;
        p.line_ack = ack;
        p.line_byte = rxb;
        prim_q.push_back(p);
    endfunction

    function automatic void queue_rand(input logic [2:0] op);
        queue_prim(op, 8'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap           <= 0;
            n_prims_in    <= 0;
            quiet         <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sequence_primitive(t_prim'(s_axis_tdata));
                n_prims_in <= n_prims_in + 1;
            end
            quiet <= (prim_q.size() < QUIET_TAIL);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (prim_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
                    gap <= $urandom_range(1, 13) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (prim_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= prim_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_pin_step exp_s;
        t_pin_word act;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall         <= 0;
            hold          <= 0;
            held_once     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                act = t_pin_word'(m_axis_tdata);
                if (pin_steps_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word tdata=%h tlast=%b", $time,
                             m_axis_tdata, m_axis_tlast);
                end else begin
                    exp_s = pin_steps_q.pop_front();
                    if (act.scl !== exp_s.w.scl) begin
                        errors++;
                        $display("%0t: scl_level exp %b act %b", $time, exp_s.w.scl, act.scl);
                    end
                    if (act.sda !== exp_s.w.sda) begin
                        errors++;
                        $display("%0t: sda_level exp %b act %b", $time, exp_s.w.sda, act.sda);
                    end
                    if (act.rx_byte !== exp_s.w.rx_byte) begin
                        errors++;
                        $display("%0t: rx_byte exp %h act %h", $time,
                                 exp_s.w.rx_byte, act.rx_byte);
                    end
                    if (act.nack !== exp_s.w.nack) begin
                        errors++;
                        $display("%0t: nack exp %b act %b", $time, exp_s.w.nack, act.nack);
                    end
                    if (act.zero !== 5'd0) begin
                        errors++;
                        $display("%0t: pad bits exp 0 act %h", $time, act.zero);
                    end
                    if (m_axis_tlast !== exp_s.eop) begin
                        errors++;
                        $display("%0t: tlast exp %b act %b", $time, exp_s.eop, m_axis_tlast);
                    end
                end
            end
            if (hold > 0) begin
                hold <= hold - 1;
                m_axis_tready <= 1'b0;
            end else if (!held_once && n_prims_in >= 40) begin
                // long back-pressure so the input side backs up
                held_once <= 1'b1;
                hold <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall <= stall - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall <= $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        int n_valid;
        int n_body;
        logic [2:0] op;
        i_rst_n = 1'b0;

        // directed words
        queue_rand(OP_START);
        queue_prim(OP_WRITE, 8'h00, 1'b0, 8'hFF);
        queue_prim(OP_WRITE, 8'hFF, 1'b1, 8'h00);
        queue_prim(OP_WRITE, 8'hA5, 1'b0, 8'h5A);
        queue_prim(OP_WRITE, 8'h5A, 1'b1, 8'hA5);
        queue_rand(OP_RESTART);
        queue_prim(OP_READ, 8'hFF, 1'b1, 8'h00);
        queue_prim(OP_READ, 8'h00, 1'b0, 8'hFF);
        queue_prim(OP_READ, 8'h3C, 1'b1, 8'hA5);
        queue_rand(OP_STOP);
        queue_rand(OP_STOP);
        queue_rand(OP_START);
        queue_rand(OP_START);
        queue_rand(OP_RESTART);
        queue_rand(OP_RESTART);
        queue_prim(3'd5, 8'hFF, 1'b1, 8'hFF);
        queue_prim(3'd6, 8'h00, 1'b0, 8'h00);
        queue_prim(3'd7, 8'hFF, 1'b1, 8'hFF);
        queue_rand(OP_READ);
        queue_rand(OP_WRITE);
        queue_rand(OP_STOP);

        // random transactions, mostly well formed
        n_valid = 0;
        while (n_valid < 130) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_rand(OP_START);
                n_valid++;
                do begin
                    n_body = $urandom_range(1, 4);
                    for (int i = 0; i < n_body; i++) begin
                        queue_rand(($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ);
                        n_valid++;
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        queue_rand(OP_RESTART);
                        n_valid++;
                    end else begin
                        break;
                    end
                end while (1);
                queue_rand(OP_STOP);
                n_valid++;
            end else begin
                op = 3'($urandom_range(0, 7));
                queue_rand(op);
                if (op <= OP_READ) n_valid++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (prim_q.size() != 0 || s_axis_tvalid || pin_steps_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0 && pin_steps_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
